// ===== design/oqli_pkg.sv =====
// Shared types and constants for the occlusion quadtree layer insert block.
`timescale 1ns / 1ps

package oqli_pkg;

  localparam int unsigned TREE_HEIGHT_DEF = 6;
  localparam int unsigned FULL_SCALE_DEF  = 65535;

  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned VAL_W   = 16;

  localparam logic [VAL_W-1:0] LAYER_MAX = '1;

  // One tile of the quadtree as it is kept in the node memory.
  typedef struct packed {
    logic [VAL_W-1:0] own_layer;
    logic [VAL_W-1:0] own_occ;
    logic [VAL_W-1:0] child_layer;
    logic [VAL_W-1:0] child_occ;
  } node_t;

  // Where a finished occlusion combine delivers its result.
  typedef enum logic [1:0] {
    PH_ACC  = 2'd0,
    PH_OWN  = 2'd1,
    PH_PROP = 2'd2
  } phase_e;

endpackage

// ===== design/oqli_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module oqli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/occlusion_quadtree_layer_insert.sv =====
// Top level of the occlusion quadtree layer insert block.
`timescale 1ns / 1ps

// Keeps a complete quadtree of screen tiles (levels 0 to TREE_HEIGHT) in one node memory
// and, for each insert word, chooses a layer from the tile and its ancestors, updates the
// tile and propagates layer and quartered occlusion up to the root. After reset the block
// clears the node memory, one tile a cycle, all NODE_COUNT tiles (5461 at the default
// height), and takes no word meanwhile. The time an insert takes is set by the single
// read port of the node memory, visited twice per ancestor, and by the one shared
// multiplier that runs each occlusion combine as product, reciprocal scale and correction.
// A word with a bad position goes straight to the output and leaves the tree untouched.
// One word is in work at a time; the result waits in an output register.
module occlusion_quadtree_layer_insert
  import oqli_pkg::*;
#(
  parameter int unsigned TREE_HEIGHT = TREE_HEIGHT_DEF,
  parameter int unsigned FULL_SCALE  = FULL_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LEVEL_W-1:0] tree_level_i,
  input  logic [POS_W-1:0]   tile_row_i,
  input  logic [POS_W-1:0]   tile_col_i,
  input  logic [VAL_W-1:0]   occlusion_amount_i,
  input  logic [VAL_W-1:0]   layer_threshold_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VAL_W-1:0]   chosen_layer_o,
  output logic [VAL_W-1:0]   tile_occlusion_after_o,
  output logic               bad_position_o
);

  localparam int unsigned NODE_COUNT =
      int'(((64'd1 << (2 * (TREE_HEIGHT + 1))) - 64'd1) / 64'd3);
  localparam int unsigned ADDR_W  = $clog2(NODE_COUNT);
  localparam logic [63:0] RECIP   = (64'd1 << 32) / FULL_SCALE;
  localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
  localparam int unsigned PROD_W  = 32 + RECIP_W;

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_TRD  = 14'b00000000000100,
    S_TGET = 14'b00000000001000,
    S_ARD  = 14'b00000000010000,
    S_AGET = 14'b00000000100000,
    S_DEC  = 14'b00000001000000,
    S_PRD  = 14'b00000010000000,
    S_PGET = 14'b00000100000000,
    S_M1   = 14'b00001000000000,
    S_M2   = 14'b00010000000000,
    S_M3   = 14'b00100000000000,
    S_M4   = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_e;

  // Tiles of level L follow all shallower levels; that base is binary 0101...01 with L ones.
  function automatic logic [ADDR_W-1:0] node_index(input logic [LEVEL_W-1:0] lvl,
                                                   input logic [POS_W-1:0]   row,
                                                   input logic [POS_W-1:0]   col);
    logic [31:0] base;
    base = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < int'(lvl)) begin
        base[2*k] = 1'b1;
      end
    end
    return ADDR_W'(base + (32'(row) << lvl) + 32'(col));
  endfunction

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [ADDR_W-1:0]    clr_cnt_q, clr_cnt_d;

  logic [LEVEL_W-1:0]   lvl_q, lvl_d, l_q, l_d;
  logic [POS_W-1:0]     row_q, row_d, col_q, col_d, r_q, r_d, c_q, c_d;
  logic [VAL_W-1:0]     occ_q, occ_d, thr_q, thr_d;
  logic                 bad_q, bad_d;
  logic [ADDR_W-1:0]    t_addr_q, t_addr_d, a_addr_q, a_addr_d;
  node_t                tile_q, tile_d, rec_q, rec_d;
  logic [VAL_W-1:0]     layer_q, layer_d, acc_q, acc_d, occsh_q, occsh_d;
  logic [VAL_W-1:0]     occ_after_q, occ_after_d;
  logic [VAL_W-1:0]     cmb_a_q, cmb_a_d, cmb_b_q, cmb_b_d;
  logic [31:0]          prod_q, prod_d, rem_q, rem_d;
  logic [RECIP_W-1:0]   est_q, est_d;

  logic                 out_valid_q, out_valid_d, out_bad_q, out_bad_d;
  logic [VAL_W-1:0]     out_layer_q, out_layer_d, out_occ_q, out_occ_d;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  node_t                ram_wdata, ram_rdata;

  logic [31:0]          mul_x;
  logic [RECIP_W-1:0]   mul_y;
  logic [PROD_W-1:0]    mul_p;

  logic                 in_acc;
  logic [LEVEL_W-1:0]   nl;
  logic [POS_W-1:0]     nr, nc;
  logic [ADDR_W-1:0]    up_addr;
  logic [VAL_W-1:0]     lay_new;
  logic [31:0]          cmb_q32, cmb_sum32, cmb_diff32;
  logic [VAL_W-1:0]     cmb_res;

  oqli_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // The shared multiplier; its operands are chosen by the combine step.
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  // Next ancestor on the way up.
  assign nl      = l_q - LEVEL_W'(1);
  assign nr      = r_q >> 1;
  assign nc      = c_q >> 1;
  assign up_addr = node_index(nl, nr, nc);

  assign lay_new = layer_q + VAL_W'((acc_q >= thr_q) && (layer_q != LAYER_MAX));

  // Final combine step: the scaled product estimate is at most one too small.
  assign cmb_q32    = 32'(est_q) + 32'(rem_q >= 32'(FULL_SCALE));
  assign cmb_sum32  = 32'(cmb_a_q) + 32'(cmb_b_q);
  assign cmb_diff32 = cmb_sum32 - cmb_q32;
  always_comb begin
    if (cmb_q32 >= cmb_sum32) begin
      cmb_res = '0;
    end else if (cmb_diff32 > 32'(LAYER_MAX)) begin
      cmb_res = '1;
    end else begin
      cmb_res = cmb_diff32[VAL_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    clr_cnt_d   = clr_cnt_q;
    lvl_d       = lvl_q;
    row_d       = row_q;
    col_d       = col_q;
    occ_d       = occ_q;
    thr_d       = thr_q;
    bad_d       = bad_q;
    l_d         = l_q;
    r_d         = r_q;
    c_d         = c_q;
    t_addr_d    = t_addr_q;
    a_addr_d    = a_addr_q;
    tile_d      = tile_q;
    rec_d       = rec_q;
    layer_d     = layer_q;
    acc_d       = acc_q;
    occsh_d     = occsh_q;
    occ_after_d = occ_after_q;
    cmb_a_d     = cmb_a_q;
    cmb_b_d     = cmb_b_q;
    prod_d      = prod_q;
    est_d       = est_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_layer_d = out_layer_q;
    out_occ_d   = out_occ_q;
    out_bad_d   = out_bad_q;
    ram_we      = 1'b0;
    ram_waddr   = t_addr_q;
    ram_wdata   = '0;
    ram_raddr   = t_addr_q;
    mul_x       = 32'(cmb_a_q);
    mul_y       = RECIP_W'(cmb_b_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(NODE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          lvl_d    = tree_level_i;
          row_d    = tile_row_i;
          col_d    = tile_col_i;
          l_d      = tree_level_i;
          r_d      = tile_row_i;
          c_d      = tile_col_i;
          occ_d    = occlusion_amount_i;
          thr_d    = (layer_threshold_i == '0) ? VAL_W'(1) : layer_threshold_i;
          t_addr_d = node_index(tree_level_i, tile_row_i, tile_col_i);
          bad_d    = (32'(tree_level_i) > TREE_HEIGHT) ||
                     ((tile_row_i >> tree_level_i) != '0) ||
                     ((tile_col_i >> tree_level_i) != '0);
          state_d  = bad_d ? S_DONE : S_TRD;
        end
      end
      S_TRD: begin
        ram_raddr = t_addr_q;
        state_d   = S_TGET;
      end
      S_TGET: begin
        tile_d  = ram_rdata;
        layer_d = ram_rdata.child_layer;
        acc_d   = ram_rdata.child_occ;
        if (ram_rdata.own_layer == ram_rdata.child_layer) begin
          cmb_a_d = ram_rdata.child_occ;
          cmb_b_d = ram_rdata.own_occ;
          phase_d = PH_ACC;
          state_d = S_M1;
        end else begin
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        if (l_q == '0) begin
          state_d = S_DEC;
        end else begin
          ram_raddr = up_addr;
          l_d       = nl;
          r_d       = nr;
          c_d       = nc;
          state_d   = S_AGET;
        end
      end
      S_AGET: begin
        if (ram_rdata.own_layer > layer_q) begin
          layer_d = ram_rdata.own_layer;
          acc_d   = ram_rdata.own_occ;
          state_d = S_ARD;
        end else if (ram_rdata.own_layer == layer_q) begin
          cmb_a_d = acc_q;
          cmb_b_d = ram_rdata.own_occ;
          phase_d = PH_ACC;
          state_d = S_M1;
        end else begin
          state_d = S_ARD;
        end
      end
      S_DEC: begin
        layer_d = lay_new;
        l_d     = lvl_q;
        r_d     = row_q;
        c_d     = col_q;
        occsh_d = occ_q;
        if (lay_new > tile_q.child_layer) begin
          ram_we      = 1'b1;
          ram_waddr   = t_addr_q;
          ram_wdata   = '{own_layer: lay_new, own_occ: occ_q,
                          child_layer: lay_new, child_occ: '0};
          occ_after_d = occ_q;
          state_d     = S_PRD;
        end else begin
          cmb_a_d = tile_q.own_occ;
          cmb_b_d = occ_q;
          phase_d = PH_OWN;
          state_d = S_M1;
        end
      end
      S_PRD: begin
        if (l_q == '0) begin
          state_d = S_DONE;
        end else begin
          ram_raddr = up_addr;
          a_addr_d  = up_addr;
          l_d       = nl;
          r_d       = nr;
          c_d       = nc;
          occsh_d   = occsh_q >> 2;
          state_d   = S_PGET;
        end
      end
      S_PGET: begin
        rec_d = ram_rdata;
        if (ram_rdata.child_layer < layer_q) begin
          ram_we    = 1'b1;
          ram_waddr = a_addr_q;
          ram_wdata = '{own_layer: ram_rdata.own_layer, own_occ: ram_rdata.own_occ,
                        child_layer: layer_q, child_occ: occsh_q};
          state_d   = S_PRD;
        end else if (ram_rdata.child_layer == layer_q) begin
          cmb_a_d = ram_rdata.child_occ;
          cmb_b_d = occsh_q;
          phase_d = PH_PROP;
          state_d = S_M1;
        end else begin
          state_d = S_PRD;
        end
      end
      S_M1: begin
        mul_x   = 32'(cmb_a_q);
        mul_y   = RECIP_W'(cmb_b_q);
        prod_d  = mul_p[31:0];
        state_d = S_M2;
      end
      S_M2: begin
        // Division by the full scale as a multiply by its reciprocal.
        mul_x   = prod_q;
        mul_y   = RECIP[RECIP_W-1:0];
        est_d   = mul_p[32 +: RECIP_W];
        state_d = S_M3;
      end
      S_M3: begin
        mul_x   = 32'(est_q);
        mul_y   = RECIP_W'(FULL_SCALE);
        rem_d   = prod_q - mul_p[31:0];
        state_d = S_M4;
      end
      S_M4: begin
        case (phase_q)
          PH_ACC: begin
            acc_d   = cmb_res;
            state_d = S_ARD;
          end
          PH_OWN: begin
            ram_we      = 1'b1;
            ram_waddr   = t_addr_q;
            ram_wdata   = '{own_layer: tile_q.own_layer, own_occ: cmb_res,
                            child_layer: tile_q.child_layer, child_occ: tile_q.child_occ};
            occ_after_d = cmb_res;
            state_d     = S_PRD;
          end
          PH_PROP: begin
            ram_we    = 1'b1;
            ram_waddr = a_addr_q;
            ram_wdata = '{own_layer: rec_q.own_layer, own_occ: rec_q.own_occ,
                          child_layer: rec_q.child_layer, child_occ: cmb_res};
            state_d   = S_PRD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_bad_d   = bad_q;
          out_layer_d = bad_q ? '0 : layer_q;
          out_occ_d   = bad_q ? '0 : occ_after_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      phase_q     <= PH_ACC;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q       <= lvl_d;
    row_q       <= row_d;
    col_q       <= col_d;
    occ_q       <= occ_d;
    thr_q       <= thr_d;
    bad_q       <= bad_d;
    l_q         <= l_d;
    r_q         <= r_d;
    c_q         <= c_d;
    t_addr_q    <= t_addr_d;
    a_addr_q    <= a_addr_d;
    tile_q      <= tile_d;
    rec_q       <= rec_d;
    layer_q     <= layer_d;
    acc_q       <= acc_d;
    occsh_q     <= occsh_d;
    occ_after_q <= occ_after_d;
    cmb_a_q     <= cmb_a_d;
    cmb_b_q     <= cmb_b_d;
    prod_q      <= prod_d;
    est_q       <= est_d;
    rem_q       <= rem_d;
    out_layer_q <= out_layer_d;
    out_occ_q   <= out_occ_d;
    out_bad_q   <= out_bad_d;
  end

  assign out_valid_o            = out_valid_q;
  assign chosen_layer_o         = out_layer_q;
  assign tile_occlusion_after_o = out_occ_q;
  assign bad_position_o         = out_bad_q;

endmodule
